// ===== rtl/core/dfim_pkg.sv =====
// ----------------------------------------------------------------------------
// dfim_pkg: shared types and constants for the device fault isolation monitor
// Health codes, opcodes, per-device entry layout, configuration set and
// register map used by the monitor and its entry update logic.
// ----------------------------------------------------------------------------
package dfim_pkg;

    localparam int DEVICE_SLOTS = 8;
    localparam int DEV_W        = 3;
    localparam int CNT_W        = 8;
    localparam int ATT_W        = 4;
    localparam int TIME_W       = 32;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX         = '1;
    localparam logic [CNT_W-1:0]  RST_THRESHOLD   = 8'd3;
    localparam logic [CNT_W-1:0]  RST_STREAK      = 8'd3;
    localparam logic [TIME_W-1:0] RST_DELAY_MS    = 32'd5000;
    localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPT = 4'd3;

    typedef enum logic [1:0] {
        H_HEALTHY    = 2'd0,
        H_DEGRADED   = 2'd1,
        H_ISOLATED   = 2'd2,
        H_RECOVERING = 2'd3
    } t_health;

    typedef enum logic [1:0] {
        OP_ACCESS  = 2'd0,
        OP_GUARDED = 2'd1,
        OP_RAW     = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Register word indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_STREAK      = 2'd1,
        REG_DELAY       = 2'd2,
        REG_MAX_ATTEMPT = 2'd3
    } t_reg;

    typedef struct packed {
        t_health            health;
        logic [CNT_W-1:0]   err_cnt;
        logic [CNT_W-1:0]   succ_cnt;
        logic [TIME_W-1:0]  stamp;
        logic [ATT_W-1:0]   attempts;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]   threshold;
        logic [CNT_W-1:0]   streak;
        logic [TIME_W-1:0]  delay_ms;
        logic [ATT_W-1:0]   max_attempts;
    } t_cfg;

    typedef struct packed {
        logic allowed;
        logic started;
    } t_verdict;

endpackage

// ===== rtl/core/dfim_in_if.sv =====
// ----------------------------------------------------------------------------
// dfim_in_if: request channel of the fault isolation monitor
// Valid/ready channel carrying one operation on one device entry.
// ----------------------------------------------------------------------------
interface dfim_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  device_index;
    logic        success;
    logic [31:0] now_ms;

    modport source (output valid, opcode, device_index, success, now_ms, input ready);
    modport sink   (input valid, opcode, device_index, success, now_ms, output ready);
endinterface

// ===== rtl/core/dfim_out_if.sv =====
// ----------------------------------------------------------------------------
// dfim_out_if: result channel of the fault isolation monitor
// Valid/ready channel carrying the decision and the entry after the step.
// ----------------------------------------------------------------------------
interface dfim_out_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [1:0]  health;
    logic [7:0]  err_cnt;
    logic [7:0]  succ_cnt;
    logic [3:0]  attempts;
    logic        recovery_started;

    modport source (output valid, allowed, health, err_cnt, succ_cnt,
                    attempts, recovery_started, input ready);
    modport sink   (input valid, allowed, health, err_cnt, succ_cnt,
                    attempts, recovery_started, output ready);
endinterface

// ===== rtl/core/dfim_update.sv =====
// ----------------------------------------------------------------------------
// dfim_update: next-state logic for one device entry
// Applies an access request, an outcome report or a clear to one entry and
// produces the access decision.
// ----------------------------------------------------------------------------
module dfim_update
    import dfim_pkg::*;
(
    input  t_entry             i_cur,
    input  t_op                i_op,
    input  logic               i_ok,
    input  logic [TIME_W-1:0]  i_now,
    input  t_cfg               i_cfg,
    output t_entry             o_nxt,
    output t_verdict           o_verdict
);

    t_entry            w_out;
    logic [TIME_W-1:0] w_elapsed;
    logic [CNT_W-1:0]  w_succ_inc;
    logic [CNT_W-1:0]  w_err_inc;

    assign w_elapsed  = i_now - i_cur.stamp;
    assign w_succ_inc = (i_cur.succ_cnt == CNT_MAX) ? i_cur.succ_cnt : i_cur.succ_cnt + 1'b1;
    assign w_err_inc  = (i_cur.err_cnt == CNT_MAX) ? i_cur.err_cnt : i_cur.err_cnt + 1'b1;

    // Outcome update shared by guarded and raw reports
    always_comb begin
        w_out = i_cur;
        if (i_ok) begin
            w_out.succ_cnt = w_succ_inc;
            if (w_succ_inc >= i_cfg.streak) begin
                w_out.err_cnt = '0;
                if (i_cur.health == H_DEGRADED) begin
                    w_out.health = H_HEALTHY;
                end
            end
        end else begin
            w_out.err_cnt  = w_err_inc;
            w_out.succ_cnt = '0;
            if (w_err_inc >= i_cfg.threshold && i_cur.health != H_ISOLATED) begin
                w_out.health = H_ISOLATED;
                w_out.stamp  = i_now;
            end else if (i_cur.health == H_HEALTHY) begin
                w_out.health = H_DEGRADED;
            end
        end
    end

    // Select the operation
    always_comb begin
        o_nxt             = i_cur;
        o_verdict.allowed = 1'b1;
        o_verdict.started = 1'b0;
        unique case (i_op)
            OP_ACCESS: begin
                if (i_cur.health == H_ISOLATED) begin
                    if (w_elapsed >= i_cfg.delay_ms && i_cur.attempts < i_cfg.max_attempts) begin
                        o_nxt.health      = H_RECOVERING;
                        o_nxt.attempts    = i_cur.attempts + 1'b1;
                        o_verdict.started = 1'b1;
                    end else begin
                        o_verdict.allowed = 1'b0;
                    end
                end
            end
            OP_GUARDED: begin
                o_nxt = w_out;
                // Resolve a recovery still in progress
                if (w_out.health == H_RECOVERING) begin
                    if (i_ok) begin
                        o_nxt.health   = H_HEALTHY;
                        o_nxt.err_cnt  = '0;
                        o_nxt.attempts = '0;
                    end else begin
                        o_nxt.health = H_ISOLATED;
                        o_nxt.stamp  = i_now;
                    end
                end
            end
            OP_RAW: begin
                o_nxt = w_out;
            end
            OP_CLEAR: begin
                o_nxt = '0;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

// ===== rtl/core/device_fault_isolation_monitor.sv =====
// ----------------------------------------------------------------------------
// device_fault_isolation_monitor: per-device circuit breaker health table
// A request passes the request register, then one table read-modify-write into
// the result register, where it waits while the result channel stalls.
// Throughput: one request per cycle while the result channel is not stalled;
// the table update is a read-modify-write of one entry, so back-to-back
// requests to the same device chain.
// Reset (i_rst_n low, synchronous): all entries healthy with zero counters and
// stamp, configuration at its defaults, both channels empty.
// ----------------------------------------------------------------------------
module device_fault_isolation_monitor
    import dfim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dfim_in_if.sink           i_req,
    dfim_out_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_entry             r_table [DEVICE_SLOTS];
    t_cfg               r_cfg;
    logic               r_in_vld;
    t_op                r_op;
    logic [DEV_W-1:0]   r_dev;
    logic               r_ok;
    logic [TIME_W-1:0]  r_now;
    logic               r_out_vld;
    t_verdict           r_verdict;
    t_entry             r_res;

    t_entry             w_nxt;
    t_verdict           w_verdict;
    logic               w_advance;
    logic               w_work;
    logic               w_cfg_wr;
    t_reg               w_reg;

    // Pipeline flow control
    assign w_advance   = !r_out_vld || o_rsp.ready;
    assign w_work      = r_in_vld && w_advance;
    assign i_req.ready = !r_in_vld || w_advance;

    assign w_reg    = t_reg'(paddr[APB_AW-1:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    dfim_update u_update (
        .i_cur     (r_table[r_dev]),
        .i_op      (r_op),
        .i_ok      (r_ok),
        .i_now     (r_now),
        .i_cfg     (r_cfg),
        .o_nxt     (w_nxt),
        .o_verdict (w_verdict)
    );

    // Control, table and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_cfg.threshold    <= RST_THRESHOLD;
            r_cfg.streak       <= RST_STREAK;
            r_cfg.delay_ms     <= RST_DELAY_MS;
            r_cfg.max_attempts <= RST_MAX_ATTEMPT;
            for (int i = 0; i < DEVICE_SLOTS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (w_advance) begin
                r_out_vld <= r_in_vld;
            end
            if (w_work) begin
                r_table[r_dev] <= w_nxt;
            end
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_THRESHOLD:   r_cfg.threshold    <= pwdata[CNT_W-1:0];
                    REG_STREAK:      r_cfg.streak       <= pwdata[CNT_W-1:0];
                    REG_DELAY:       r_cfg.delay_ms     <= pwdata[TIME_W-1:0];
                    REG_MAX_ATTEMPT: r_cfg.max_attempts <= pwdata[ATT_W-1:0];
                    default:         r_cfg              <= r_cfg;
                endcase
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op  <= t_op'(i_req.opcode);
            r_dev <= i_req.device_index;
            r_ok  <= i_req.success;
            r_now <= i_req.now_ms;
        end
        if (w_work) begin
            r_verdict <= w_verdict;
            r_res     <= w_nxt;
        end
    end

    // Register read back
    always_comb begin
        unique case (w_reg)
            REG_THRESHOLD:   prdata = {{(APB_DW-CNT_W){1'b0}}, r_cfg.threshold};
            REG_STREAK:      prdata = {{(APB_DW-CNT_W){1'b0}}, r_cfg.streak};
            REG_DELAY:       prdata = r_cfg.delay_ms;
            REG_MAX_ATTEMPT: prdata = {{(APB_DW-ATT_W){1'b0}}, r_cfg.max_attempts};
            default:         prdata = '0;
        endcase
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.allowed          = r_verdict.allowed;
    assign o_rsp.recovery_started = r_verdict.started;
    assign o_rsp.health           = r_res.health;
    assign o_rsp.err_cnt          = r_res.err_cnt;
    assign o_rsp.succ_cnt         = r_res.succ_cnt;
    assign o_rsp.attempts         = r_res.attempts;

endmodule

// ===== rtl/core/dfim_checker.sv =====
// ----------------------------------------------------------------------------
// dfim_checker: port-level checks for the fault isolation monitor
// Watches the result channel for stall behavior and decision consistency.
// ----------------------------------------------------------------------------
module dfim_checker
    import dfim_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_allowed,
    input logic [1:0] i_health,
    input logic [3:0] i_attempts,
    input logic       i_started
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_allowed) && $stable(i_health)
            && $stable(i_started) && $stable(i_attempts))
        else $error("result changed while stalled");

    // Only an isolated device is denied, and a denial never starts recovery
    a_deny_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_allowed |-> i_health == H_ISOLATED && !i_started)
        else $error("denied device not isolated");

    // A started recovery is allowed, recovering and has used an attempt
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_started |-> i_allowed && i_health == H_RECOVERING && i_attempts != 4'd0)
        else $error("recovery start inconsistent");

endmodule

bind device_fault_isolation_monitor dfim_checker u_dfim_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_rsp.valid),
    .i_ready    (o_rsp.ready),
    .i_allowed  (o_rsp.allowed),
    .i_health   (o_rsp.health),
    .i_attempts (o_rsp.attempts),
    .i_started  (o_rsp.recovery_started)
);
